### rtl/core/sdagg_pkg.sv
// ----------------------------------------------------------------------------
// sdagg_pkg
// Types and constants shared by the series downsample aggregator.
// ----------------------------------------------------------------------------
package sdagg_pkg;

  localparam int unsigned SUM_BITS      = 48;
  localparam int unsigned IN_BITS       = 32;
  localparam int unsigned GSIZE_BITS    = 10;
  localparam int unsigned SKIP_BITS     = 9;
  localparam int unsigned GPOS_BITS     = 9;
  localparam int unsigned SPOS_BITS     = 10;
  localparam int unsigned METHOD_BITS   = 2;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 10;

  typedef logic [METHOD_BITS-1:0]  method_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam method_t METHOD_LAST = 2'd0;
  localparam method_t METHOD_MEAN = 2'd1;
  localparam method_t METHOD_SUM  = 2'd2;

  localparam cfg_idx_t CFG_IDX_METHOD     = 2'd0;
  localparam cfg_idx_t CFG_IDX_GROUP_SIZE = 2'd1;
  localparam cfg_idx_t CFG_IDX_SKIP_COUNT = 2'd2;

  typedef struct packed {
    logic signed [IN_BITS-1:0] sample_value;
    logic                      sample_missing;
    logic                      series_start;
  } sample_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] result_value;
    logic                       result_missing;
  } result_t;

  typedef struct packed {
    method_t                method;
    logic [GSIZE_BITS-1:0]  group_size;
    logic [SKIP_BITS-1:0]   skip_count;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_MEAN,
    OP_SKIP
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [SUM_BITS-1:0]   value;
    logic                  missing;
    logic [GSIZE_BITS-1:0] divisor;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

### rtl/core/series_downsample_aggregator_unit.sv
// ----------------------------------------------------------------------------
// series_downsample_aggregator_unit
// Boxcar decimation of a sample series with last, mean and sum modes.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while full is low. Within a group the
// front end accumulates each sample as it is taken, and results that need
// no division (last, sum, missing) pass through the command queue to the
// result queue once the commands ahead of them are done. A mean result,
// and every skipped sample past index zero, goes through the shared restoring
// divider in the back end (load, 48 quotient steps, write). A two-entry
// command queue sits between front and back and a two-entry result queue
// holds finished results until popped. The configuration port is always
// ready; write it only while the block idles.
module series_downsample_aggregator_unit #(
  parameter int unsigned MAX_GROUP   = 512,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  sdagg_pkg::sample_t                    in_item_i,
  output logic                                  empty,
  input  logic                                  pop,
  output sdagg_pkg::result_t                    result_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sdagg_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [sdagg_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  import sdagg_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    accept;
  logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t    cmd_in, cmd_out;
  logic    res_push, res_full;
  result_t res_in;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign full        = cmd_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_METHOD:     cfg_d.method     = cfg_data_i[METHOD_BITS-1:0];
        CFG_IDX_GROUP_SIZE: cfg_d.group_size = cfg_data_i[GSIZE_BITS-1:0];
        CFG_IDX_SKIP_COUNT: cfg_d.skip_count = cfg_data_i[SKIP_BITS-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{method: METHOD_LAST, group_size: GSIZE_BITS'(2), skip_count: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sdagg_front #(
    .MAX_GROUP   (MAX_GROUP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .sample_i   (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  sdagg_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  sdagg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  sdagg_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

### rtl/core/sdagg_fifo.sv
// ----------------------------------------------------------------------------
// sdagg_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module sdagg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/sdagg_front.sv
// ----------------------------------------------------------------------------
// sdagg_front
// Takes samples, tracks skip and group position, accumulates the group sum
// and sends the back end a command per result and per skip past index zero.
// ----------------------------------------------------------------------------
module sdagg_front #(
  parameter int unsigned MAX_GROUP   = 512,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdagg_pkg::cfg_t   cfg_i,
  input  logic              accept_i,
  input  sdagg_pkg::sample_t sample_i,
  output logic              cmd_push_o,
  output sdagg_pkg::cmd_t   cmd_o
);

  import sdagg_pkg::*;

  logic [SPOS_BITS-1:0]  spos_q, spos_d, spos_c;
  logic [GPOS_BITS-1:0]  gpos_q, gpos_d, gpos_c, gpos_n;
  logic [SUM_BITS-1:0]   sum_q, sum_d, sum_c, sum_n;
  logic                  gmiss_q, gmiss_d, gmiss_c, gmiss_n;
  logic [GSIZE_BITS-1:0] grp;
  logic [SUM_BITS-1:0]   zx, sx;
  logic                  complete;

  // effective group size
  always_comb begin
    if (cfg_i.group_size == '0) begin
      grp = GSIZE_BITS'(1);
    end else if (32'(cfg_i.group_size) > MAX_GROUP) begin
      grp = GSIZE_BITS'(MAX_GROUP);
    end else begin
      grp = cfg_i.group_size;
    end
  end

  // sign extend from the sample width
  always_comb begin
    zx = {{(SUM_BITS - IN_BITS){1'b0}}, sample_i.sample_value};
    for (int i = 0; i < SUM_BITS; i++) begin
      sx[i] = (i < SAMPLE_BITS) ? zx[i] : zx[SAMPLE_BITS-1];
    end
  end

  assign spos_c  = sample_i.series_start ? '0 : spos_q;
  assign gpos_c  = sample_i.series_start ? '0 : gpos_q;
  assign sum_c   = sample_i.series_start ? '0 : sum_q;
  assign gmiss_c = sample_i.series_start ? 1'b0 : gmiss_q;

  always_comb begin
    sum_n   = sum_c;
    gmiss_n = gmiss_c;
    if (cfg_i.method != METHOD_LAST) begin
      if (sample_i.sample_missing) begin
        gmiss_n = 1'b1;
      end else begin
        sum_n = sum_c + sx;
      end
    end
    gpos_n   = gpos_c + GPOS_BITS'(1);
    complete = (gpos_n == '0) || (GSIZE_BITS'(gpos_n) >= grp);
  end

  always_comb begin
    spos_d      = spos_q;
    gpos_d      = gpos_q;
    sum_d       = sum_q;
    gmiss_d     = gmiss_q;
    cmd_push_o  = 1'b0;
    cmd_o       = '{op: OP_EMIT, value: '0, missing: 1'b1, divisor: grp};
    if (accept_i) begin
      if (spos_c < SPOS_BITS'(cfg_i.skip_count)) begin
        spos_d  = spos_c + SPOS_BITS'(1);
        gpos_d  = gpos_c;
        sum_d   = sum_c;
        gmiss_d = gmiss_c;
        if (spos_c != '0) begin
          cmd_push_o = 1'b1;
          cmd_o.op    = OP_SKIP;
          cmd_o.value = SUM_BITS'(spos_c);
        end
      end else begin
        spos_d = spos_c;
        if (complete) begin
          gpos_d     = '0;
          sum_d      = '0;
          gmiss_d    = 1'b0;
          cmd_push_o = 1'b1;
          if (cfg_i.method == METHOD_LAST) begin
            cmd_o.missing = sample_i.sample_missing;
            cmd_o.value   = sample_i.sample_missing ? '0 : sx;
          end else if (gmiss_n) begin
            cmd_o.missing = 1'b1;
          end else if (cfg_i.method == METHOD_MEAN) begin
            cmd_o.op      = OP_MEAN;
            cmd_o.missing = 1'b0;
            cmd_o.value   = sum_n;
          end else begin
            cmd_o.missing = 1'b0;
            cmd_o.value   = sum_n;
          end
        end else begin
          gpos_d  = gpos_n;
          sum_d   = sum_n;
          gmiss_d = gmiss_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spos_q  <= '0;
      gpos_q  <= '0;
      sum_q   <= '0;
      gmiss_q <= 1'b0;
    end else begin
      spos_q  <= spos_d;
      gpos_q  <= gpos_d;
      sum_q   <= sum_d;
      gmiss_q <= gmiss_d;
    end
  end

endmodule

### rtl/core/sdagg_back.sv
// ----------------------------------------------------------------------------
// sdagg_back
// Executes commands: passes direct results through and runs a shared
// restoring divider, one quotient bit per cycle, for mean results and for
// the group boundary test of skipped samples.
// ----------------------------------------------------------------------------
module sdagg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  sdagg_pkg::cmd_t    cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output sdagg_pkg::result_t res_o
);

  import sdagg_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(SUM_BITS);
  localparam logic [CNT_BITS-1:0] STEP_LAST = CNT_BITS'(SUM_BITS - 1);

  back_state_e           state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  op_e                   op_q;
  logic                  neg_q;
  logic [GSIZE_BITS-1:0] div_q;
  logic [GSIZE_BITS-1:0] rem_q, rem_n;
  logic [SUM_BITS-1:0]   quo_q;
  logic [GSIZE_BITS:0]   trial, diff;
  logic                  ge;
  logic [SUM_BITS-1:0]   mag;
  logic                  load;

  assign trial = {rem_q, quo_q[SUM_BITS-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});
  assign rem_n = ge ? diff[GSIZE_BITS-1:0] : trial[GSIZE_BITS-1:0];
  assign mag   = cmd_i.value[SUM_BITS-1] ? (~cmd_i.value + SUM_BITS'(1)) : cmd_i.value;
  assign load  = (state_q == BK_IDLE) && !cmd_empty_i && (cmd_i.op != OP_EMIT);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      BK_IDLE: begin
        if (load) begin
          state_d = BK_DIV;
          cnt_d   = '0;
        end
      end
      BK_DIV: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == STEP_LAST) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if ((op_q == OP_SKIP) && (rem_q != '0)) begin
          state_d = BK_IDLE;
        end else if (!res_full_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{result_value: '0, result_missing: 1'b1};
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.op == OP_EMIT) begin
            cmd_pop_o  = !res_full_i;
            res_push_o = !res_full_i;
            res_o      = '{result_value: cmd_i.value, result_missing: cmd_i.missing};
          end else begin
            cmd_pop_o = 1'b1;
          end
        end
      end
      BK_DONE: begin
        if (op_q == OP_SKIP) begin
          res_push_o = (rem_q == '0) && !res_full_i;
        end else begin
          res_push_o = !res_full_i;
          res_o      = '{result_value: neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q,
                         result_missing: 1'b0};
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q  <= cmd_i.op;
      neg_q <= cmd_i.value[SUM_BITS-1];
      div_q <= cmd_i.divisor;
      rem_q <= '0;
      quo_q <= mag;
    end else if (state_q == BK_DIV) begin
      rem_q <= rem_n;
      quo_q <= {quo_q[SUM_BITS-2:0], ge};
    end
  end

endmodule

### rtl/core/sdagg_checker.sv
// ----------------------------------------------------------------------------
// sdagg_checker
// Port level checks for the series downsample aggregator.
// ----------------------------------------------------------------------------
module sdagg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input sdagg_pkg::result_t result_o
);

  import sdagg_pkg::*;

  // queue comes out of reset empty
  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

  // a missing result carries a zero value
  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!result_o.result_missing || (result_o.result_value == '0)))
    else $error("missing result with nonzero value");

  // full only rises after an input transaction
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without an input transaction");

  // waiting result holds until popped
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed before pop");

endmodule

bind series_downsample_aggregator_unit sdagg_checker u_sdagg_checker (.*);

### tb/tb_series_downsample_aggregator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_series_downsample_aggregator_unit
// Self-checking bench for the series downsample aggregator. A scoreboard class
// tracks skip and group progress, predicts each last, mean or sum result from
// the accepted samples and compares every popped result against it. Directed
// samples cover value extremes, every method, the skip phase and register
// changes mid-series, then random series run over many register settings
// with random idle bursts on both the sample and the result side.
// ----------------------------------------------------------------------------
module tb_series_downsample_aggregator_unit;
  import sdagg_pkg::*;

  localparam int unsigned GROUP_LIMIT   = 512;
  localparam int          SETTLE_CYCLES = 200;
  localparam method_t     METHOD_RSVD   = 2'd3;

  class downsample_scoreboard;
    method_t               mode        = METHOD_LAST;
    logic [GSIZE_BITS-1:0] group_size  = 10'd2;
    logic [SKIP_BITS-1:0]  skip_count  = '0;
    logic [SPOS_BITS-1:0]  skip_pos    = '0;
    logic [GPOS_BITS-1:0]  group_pos   = '0;
    logic signed [SUM_BITS-1:0] acc    = '0;
    logic                  acc_missing = 1'b0;
    result_t               pending_results[$];
    int                    errors      = 0;

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_IDX_METHOD:     mode = method_t'(data[METHOD_BITS-1:0]);
        CFG_IDX_GROUP_SIZE: group_size = data[GSIZE_BITS-1:0];
        CFG_IDX_SKIP_COUNT: skip_count = data[SKIP_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      logic [GSIZE_BITS-1:0]      g;
      logic [SPOS_BITS-1:0]       f;
      logic signed [SUM_BITS-1:0] sv;
      logic signed [SUM_BITS-1:0] total;
      result_t                    r;
      if (group_size == 0) begin
        g = 10'd1;
      end else if (group_size > GROUP_LIMIT) begin
        g = GSIZE_BITS'(GROUP_LIMIT);
      end else begin
        g = group_size;
      end
      sv = {{(SUM_BITS-IN_BITS){s.sample_value[IN_BITS-1]}}, s.sample_value};
      if (s.series_start) begin
        skip_pos    = '0;
        group_pos   = '0;
        acc         = '0;
        acc_missing = 1'b0;
      end
      if (skip_pos < SPOS_BITS'(skip_count)) begin
        f        = skip_pos;
        skip_pos = skip_pos + 1'b1;
        if (f != 0 && (f % g) == 0) begin
          r.result_value   = '0;
          r.result_missing = 1'b1;
          pending_results.push_back(r);
        end
        return;
      end
      if (mode != METHOD_LAST) begin
        if (s.sample_missing) begin
          acc_missing = 1'b1;
        end else begin
          acc = acc + sv;
        end
      end
      group_pos = group_pos + 1'b1;
      if (group_pos != 0 && GSIZE_BITS'(group_pos) < g) return;
      if (mode == METHOD_LAST) begin
        r.result_missing = s.sample_missing;
        r.result_value   = s.sample_missing ? '0 : sv;
      end else if (acc_missing) begin
        r.result_missing = 1'b1;
        r.result_value   = '0;
      end else begin
        total = acc;
        if (mode == METHOD_MEAN) begin
          total = total / $signed({{(SUM_BITS-GSIZE_BITS){1'b0}}, g});
        end
        r.result_missing = 1'b0;
        r.result_value   = total;
      end
      pending_results.push_back(r);
      group_pos   = '0;
      acc         = '0;
      acc_missing = 1'b0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual value %0d missing %0b",
                 $time, $signed(got.result_value), got.result_missing);
        return;
      end
      want = pending_results.pop_front();
      if (got.result_value !== want.result_value) begin
        errors++;
        $display("%0t: result_value mismatch, expected %0d, actual %0d",
                 $time, $signed(want.result_value), $signed(got.result_value));
      end
      if (got.result_missing !== want.result_missing) begin
        errors++;
        $display("%0t: result_missing mismatch, expected %0b, actual %0b",
                 $time, want.result_missing, got.result_missing);
      end
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     push        = 1'b0;
  logic                     full;
  sample_t                  sample_item = '0;
  logic                     empty;
  logic                     pop         = 1'b0;
  result_t                  result_o;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready_o;
  cfg_idx_t                 cfg_index   = CFG_IDX_METHOD;
  logic [CFG_DATA_BITS-1:0] cfg_data    = '0;

  bit push_idle_on = 1'b1;
  bit pop_idle_on  = 1'b1;
  int pop_hold     = 0;

  method_t               phase_mode  [4]  = '{METHOD_LAST, METHOD_MEAN, METHOD_SUM, METHOD_RSVD};
  logic [GSIZE_BITS-1:0] phase_group [10] = '{10'd1, 10'd2, 10'd3, 10'd4, 10'd5,
                                              10'd0, 10'd8, 10'd7, 10'd16, 10'd6};

  downsample_scoreboard sb = new();

  series_downsample_aggregator_unit #(
    .MAX_GROUP  (GROUP_LIMIT),
    .SAMPLE_BITS(IN_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (sample_item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) sb.write_reg(cfg_index, cfg_data);
      if (push && !full) sb.note_sample(sample_item);
      if (pop && !empty) sb.check_result(result_o);
    end
  end

  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (pop_idle_on && $urandom_range(0, 5) == 0) begin
      pop      <= 1'b0;
      pop_hold <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic push_sample(logic [IN_BITS-1:0] value, bit missing, bit start);
    sample_t s;
    s.sample_value   = value;
    s.sample_missing = missing;
    s.series_start   = start;
    sample_item <= s;
    push        <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    if (push_idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_regs(method_t m, logic [GSIZE_BITS-1:0] g, logic [SKIP_BITS-1:0] skip);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(CFG_IDX_METHOD, CFG_DATA_BITS'(m));
    write_reg(CFG_IDX_GROUP_SIZE, CFG_DATA_BITS'(g));
    write_reg(CFG_IDX_SKIP_COUNT, CFG_DATA_BITS'(skip));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_series(int n_items, int miss_odds, bit hold_off);
    logic [IN_BITS-1:0] value;
    bit                 missing;
    bit                 start;
    int                 series_left;
    series_left = 0;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 7))
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = IN_BITS'($urandom_range(0, 255)) - 32'd128;
        default: value = $urandom;
      endcase
      missing = (miss_odds > 0) && ($urandom_range(1, miss_odds) == 1);
      if (series_left == 0) begin
        start       = 1'b1;
        series_left = $urandom_range(1, 48);
      end else begin
        start = ($urandom_range(0, 31) == 0);
      end
      series_left--;
      if (hold_off && i == n_items / 2) wait_drained();
      push_sample(value, missing, start);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: last sample, groups of two, no skip
    push_sample(32'h7FFF_FFFF, 1'b0, 1'b1);
    push_sample(32'h8000_0000, 1'b0, 1'b0);
    push_sample(32'h0000_0000, 1'b1, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1, 1'b0);

    // skip phase emits a missing result at index three
    set_regs(METHOD_SUM, 10'd3, 9'd4);
    push_sample(32'h1234_5678, 1'b0, 1'b1);
    push_sample(32'h0000_0000, 1'b1, 1'b0);
    push_sample(32'h0000_0001, 1'b0, 1'b0);
    push_sample(32'h0000_0002, 1'b0, 1'b0);
    repeat (3) push_sample(32'h7FFF_FFFF, 1'b0, 1'b0);

    // zero group size acts as one
    set_regs(METHOD_MEAN, 10'd0, 9'd0);
    push_sample(32'hFFFF_FFFD, 1'b0, 1'b1);

    // mean truncates toward zero
    set_regs(METHOD_MEAN, 10'd2, 9'd0);
    push_sample(32'hFFFF_FFFD, 1'b0, 1'b1);
    push_sample(32'h0000_0000, 1'b0, 1'b0);
    push_sample(32'h8000_0000, 1'b0, 1'b0);
    push_sample(32'h8000_0000, 1'b0, 1'b0);

    set_regs(METHOD_RSVD, 10'd2, 9'd0);
    push_sample(32'h0000_0005, 1'b0, 1'b1);
    push_sample(32'hFFFF_FFFA, 1'b0, 1'b0);

    // longest skip, then skip and group size changed mid-series
    set_regs(METHOD_SUM, 10'd3, 9'd511);
    push_sample(32'h0000_0010, 1'b0, 1'b1);
    repeat (6) push_sample($urandom, 1'b0, 1'b0);
    set_regs(METHOD_SUM, 10'd1023, 9'd0);
    repeat (3) push_sample($urandom, 1'b0, 1'b0);
    set_regs(METHOD_SUM, 10'd2, 9'd0);
    push_sample(32'h0000_0003, 1'b0, 1'b0);

    for (int p = 0; p < 10; p++) begin
      push_idle_on = (p % 3 != 2);
      pop_idle_on  = (p % 3 != 1);
      set_regs(phase_mode[p % 4], phase_group[p], SKIP_BITS'($urandom_range(0, 12)));
      run_series(9, 8, p == 4);
    end

    // largest group, clamped to the maximum
    push_idle_on = 1'b1;
    pop_idle_on  = 1'b1;
    set_regs(METHOD_MEAN, 10'd1023, 9'd0);
    push_sample($urandom, 1'b0, 1'b1);
    repeat (511) push_sample($urandom, 1'b0, 1'b0);

    push_idle_on = 1'b0;
    pop_idle_on  = 1'b0;
    set_regs(METHOD_SUM, 10'd4, 9'd2);
    run_series(20, 8, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
rtl/core/sdagg_pkg.sv
rtl/core/sdagg_fifo.sv
rtl/core/sdagg_front.sv
rtl/core/sdagg_back.sv
rtl/core/series_downsample_aggregator_unit.sv
rtl/core/sdagg_checker.sv
tb/tb_series_downsample_aggregator_unit.sv
